// ----- src/s2cd_pkg.sv -----
package s2cd_pkg;

	// Divisors for the day, hour and minute splits.
	localparam logic [16:0] SecsPerDay  = 17'd86400;
	localparam logic [16:0] SecsPerHour = 17'd3600;
	localparam logic [16:0] SecsPerMin  = 17'd60;

	// Reciprocals rounded up, so that (x >> pre) * recip >> post is the exact quotient
	// over each operand's range: 86400 = 2^7 * 675, 3600 = 2^4 * 225, 60 = 2^2 * 15.
	localparam logic [25:0] RecipDay  = 26'd50903317;
	localparam logic [13:0] RecipHour = 14'd9321;
	localparam logic [10:0] RecipMin  = 11'd1093;

	localparam logic [8:0] DaysLeapYear = 9'd366;
	localparam logic [8:0] DaysYear     = 9'd365;

	typedef enum logic [1:0] {
		OP_DAYS = 2'd0,
		OP_HOUR = 2'd1,
		OP_MIN  = 2'd2
	} div_op_t;

	typedef struct packed {
		logic [31:0] epoch_seconds;
	} in_item_t;

	typedef struct packed {
		logic [6:0] year_offset;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic       out_of_range;
	} out_item_t;

	typedef struct packed {
		logic    load;
		logic    div_step;
		logic    div_next;
		div_op_t op;
		logic    yr_step;
		logic    mon_step;
		logic    out_load;
		logic    oor;
	} cmd_t;

	typedef struct packed {
		logic yr_fit;
		logic yr_last;
		logic mon_fit;
	} status_t;

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ----- src/s2cd_stream_if.sv -----
interface s2cd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/s2cd_ctrl.sv -----
module s2cd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  s2cd_pkg::status_t status,
	output s2cd_pkg::cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_NEXT  = 6'b000100,
		ST_YEAR  = 6'b001000,
		ST_MONTH = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	s2cd_pkg::div_op_t   op_q, op_d;
	logic                oor_q, oor_d;
	logic                out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		oor_d   = oor_q;
		cmd     = '0;
		cmd.op  = op_q;
		cmd.oor = oor_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					op_d     = s2cd_pkg::OP_DAYS;
					oor_d    = 1'b0;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				state_d      = ST_NEXT;
			end
			ST_NEXT: begin
				cmd.div_next = 1'b1;
				case (op_q)
					s2cd_pkg::OP_DAYS: begin
						op_d    = s2cd_pkg::OP_HOUR;
						state_d = ST_DIV;
					end
					s2cd_pkg::OP_HOUR: begin
						op_d    = s2cd_pkg::OP_MIN;
						state_d = ST_DIV;
					end
					default: begin
						state_d = ST_YEAR;
					end
				endcase
			end
			ST_YEAR: begin
				if (status.yr_fit) begin
					state_d = ST_MONTH;
				end else if (status.yr_last) begin
					oor_d   = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.yr_step = 1'b1;
				end
			end
			ST_MONTH: begin
				if (status.mon_fit) begin
					state_d = ST_DONE;
				end else begin
					cmd.mon_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= s2cd_pkg::OP_DAYS;
			oor_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			oor_q   <= oor_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/s2cd_dp.sv -----
module s2cd_dp #(
	parameter int YEAR_SPAN = 100
) (
	input  logic                clk,
	input  s2cd_pkg::in_item_t  in_item,
	input  s2cd_pkg::cmd_t      cmd,
	output s2cd_pkg::status_t   status,
	output s2cd_pkg::out_item_t out_item
);

	logic [31:0] dvd_q;
	logic [16:0] divisor_q;
	logic [15:0] quo_q;
	logic [15:0] days_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic [6:0]  yr_q;
	logic [3:0]  mon_q;
	s2cd_pkg::out_item_t out_q;

	logic [50:0] day_prod;
	logic [26:0] hour_prod;
	logic [20:0] min_prod;
	logic [32:0] back_prod;
	logic [31:0] part_rem;
	logic        leap;
	logic [8:0]  yr_len;
	logic [4:0]  mon_len;

	// Quotients by reciprocal multiplication; the low factor of each divisor is shifted out.
	assign day_prod  = 51'(dvd_q[31:7]) * 51'(s2cd_pkg::RecipDay);
	assign hour_prod = 27'(dvd_q[16:4]) * 27'(s2cd_pkg::RecipHour);
	assign min_prod  = 21'(dvd_q[11:2]) * 21'(s2cd_pkg::RecipMin);

	// The remainder follows in the next cycle from the registered quotient.
	assign back_prod = 33'(quo_q) * 33'(divisor_q);
	assign part_rem  = dvd_q - back_prod[31:0];

	// Years 2000..2099: 2000 is a multiple of 400, so every fourth year leaps.
	assign leap    = (yr_q[1:0] == 2'b00);
	assign yr_len  = leap ? s2cd_pkg::DaysLeapYear : s2cd_pkg::DaysYear;
	assign mon_len = s2cd_pkg::month_days(mon_q, leap);

	assign status.yr_fit  = (days_q < {7'd0, yr_len});
	assign status.yr_last = (yr_q == 7'(YEAR_SPAN - 1));
	assign status.mon_fit = (days_q < {11'd0, mon_len});

	assign out_item = out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q     <= in_item.epoch_seconds;
			divisor_q <= s2cd_pkg::SecsPerDay;
			yr_q      <= '0;
			mon_q     <= 4'd1;
		end
		if (cmd.div_step) begin
			case (cmd.op)
				s2cd_pkg::OP_DAYS: begin
					quo_q <= day_prod[50:35];
				end
				s2cd_pkg::OP_HOUR: begin
					quo_q <= {10'd0, hour_prod[26:21]};
				end
				default: begin
					quo_q <= {9'd0, min_prod[20:14]};
				end
			endcase
		end
		if (cmd.div_next) begin
			case (cmd.op)
				s2cd_pkg::OP_DAYS: begin
					days_q    <= quo_q;
					dvd_q     <= {15'd0, part_rem[16:0]};
					divisor_q <= s2cd_pkg::SecsPerHour;
				end
				s2cd_pkg::OP_HOUR: begin
					hour_q    <= quo_q[4:0];
					dvd_q     <= {20'd0, part_rem[11:0]};
					divisor_q <= s2cd_pkg::SecsPerMin;
				end
				default: begin
					minute_q <= quo_q[5:0];
					second_q <= part_rem[5:0];
				end
			endcase
		end
		if (cmd.yr_step) begin
			days_q <= days_q - {7'd0, yr_len};
			yr_q   <= yr_q + 7'd1;
		end
		if (cmd.mon_step) begin
			days_q <= days_q - {11'd0, mon_len};
			mon_q  <= mon_q + 4'd1;
		end
		if (cmd.out_load) begin
			out_q.hour         <= hour_q;
			out_q.minute       <= minute_q;
			out_q.second       <= second_q;
			out_q.out_of_range <= cmd.oor;
			if (cmd.oor) begin
				out_q.year_offset <= '0;
				out_q.month       <= '0;
				out_q.day         <= '0;
			end else begin
				out_q.year_offset <= yr_q;
				out_q.month       <= mon_q;
				out_q.day         <= days_q[4:0] + 5'd1;
			end
		end
	end

endmodule

// ----- src/seconds_to_calendar_date.sv -----
// Sequence: a quotient and a remainder step each for days, hours and minutes, a step for each
// year walked plus a final year check, a step for each month walked plus a final month check,
// and a load of the output register.
// One item at a time: the next transfer is taken in the cycle after the result is loaded,
// and the load waits until the output register drains.
// Reset clears the controller and the output valid flag; no clearing pass.
module seconds_to_calendar_date #(
	parameter int YEAR_SPAN = 100
) (
	input logic         clk,
	input logic         arst_n,
	s2cd_stream_if.sink   secs,
	s2cd_stream_if.source date
);

	s2cd_pkg::cmd_t      cmd;
	s2cd_pkg::status_t   status;
	s2cd_pkg::in_item_t  in_item;
	s2cd_pkg::out_item_t out_item;

	assign in_item.epoch_seconds = secs.data.epoch_seconds;
	assign date.data             = out_item;

	s2cd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (secs.valid),
		.in_ready  (secs.ready),
		.out_valid (date.valid),
		.out_ready (date.ready),
		.status    (status),
		.cmd       (cmd)
	);

	s2cd_dp #(
		.YEAR_SPAN (YEAR_SPAN)
	) u_dp (
		.clk      (clk),
		.in_item  (in_item),
		.cmd      (cmd),
		.status   (status),
		.out_item (out_item)
	);

endmodule

// ----- bench/seconds_to_calendar_date_tb.sv -----
`timescale 1ns / 100ps

module seconds_to_calendar_date_tb;

	localparam int YEAR_SPAN = 100;
	localparam int RANDOM_ITEMS = 1500;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 250;
	localparam int unsigned SECS_DAY = 86400;

	logic clk;
	logic arst_n;

	s2cd_stream_if #(.T(s2cd_pkg::in_item_t)) secs_if ();
	s2cd_stream_if #(.T(s2cd_pkg::out_item_t)) date_if ();

	seconds_to_calendar_date #(
		.YEAR_SPAN(YEAR_SPAN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.secs(secs_if),
		.date(date_if)
	);

	function automatic bit is_leap(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_len(int unsigned m, bit leap);
		case (m)
			2: return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	// Days from the epoch to the first of month m in year 2000 + y.
	function automatic longint unsigned days_to_month(int unsigned y, int unsigned m);
		longint unsigned d;
		d = 0;
		for (int unsigned i = 0; i < y; i++) d += is_leap(2000 + i) ? 366 : 365;
		for (int unsigned k = 1; k < m; k++) d += month_len(k, is_leap(2000 + y));
		return d;
	endfunction

	class date_checker;
		s2cd_pkg::out_item_t pending_dates[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function s2cd_pkg::out_item_t predict_date(logic [31:0] secs);
			int unsigned tod, days, len, yr, mon;
			bit found, placed, lp;
			s2cd_pkg::out_item_t d;
			tod = secs % SECS_DAY;
			days = secs / SECS_DAY;
			found = 0;
			placed = 0;
			yr = 0;
			mon = 0;
			for (int unsigned i = 0; i < YEAR_SPAN; i++) begin
				if (!found) begin
					len = is_leap(2000 + i) ? 366 : 365;
					if (days < len) begin
						found = 1;
						yr = i;
					end else begin
						days -= len;
					end
				end
			end
			if (found) begin
				lp = is_leap(2000 + yr);
				mon = 12;
				for (int unsigned m = 1; m <= 12; m++) begin
					if (!placed) begin
						len = month_len(m, lp);
						if (days < len) begin
							placed = 1;
							mon = m;
						end else begin
							days -= len;
						end
					end
				end
				days = days + 1;
			end else begin
				days = 0;
			end
			d.year_offset = yr[6:0];
			d.month = mon[3:0];
			d.day = days[4:0];
			d.hour = 5'(tod / 3600);
			d.minute = 6'((tod % 3600) / 60);
			d.second = 6'(tod % 60);
			d.out_of_range = !found;
			return d;
		endfunction

		function void note_seconds(s2cd_pkg::in_item_t item);
			pending_dates.push_back(predict_date(item.epoch_seconds));
		endfunction

		function void compare(string name, int unsigned exp_val, int unsigned act_val);
			if (exp_val != act_val) begin
				$error("%s: expected %0d, got %0d", name, exp_val, act_val);
				errors++;
			end
		endfunction

		function void check_date(s2cd_pkg::out_item_t got);
			s2cd_pkg::out_item_t want;
			if (pending_dates.size() == 0) begin
				$error("date transfer with no conversion pending");
				errors++;
				return;
			end
			want = pending_dates.pop_front();
			compare("year_offset", want.year_offset, got.year_offset);
			compare("month", want.month, got.month);
			compare("day", want.day, got.day);
			compare("hour", want.hour, got.hour);
			compare("minute", want.minute, got.minute);
			compare("second", want.second, got.second);
			compare("out_of_range", want.out_of_range, got.out_of_range);
		endfunction

		function int pending();
			return pending_dates.size();
		endfunction
	endclass

	date_checker dates;
	int idle_cycles;
	bit send_burst;
	bit take_burst;

	always #1 clk = ~clk;

	initial begin
		clk = 0;
		arst_n = 0;
		secs_if.valid = 0;
		secs_if.data = '0;
		date_if.ready = 0;
		idle_cycles = 0;
		send_burst = 0;
		take_burst = 0;
		dates = new();
	end

	// Stall watchdog: any transfer on either side restarts the count.
	always @(posedge clk) begin
		if ((secs_if.valid && secs_if.ready) || (date_if.valid && date_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int unsigned draw_gap(bit burst);
		return burst ? 0 : $urandom_range(0, 9);
	endfunction

	task automatic send_seconds(logic [31:0] s);
		int unsigned gap;
		s2cd_pkg::in_item_t item;
		if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
		gap = draw_gap(send_burst);
		item.epoch_seconds = s;
		if (gap > 0) begin
			secs_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		secs_if.valid <= 1'b1;
		secs_if.data <= item;
		do @(posedge clk); while (!secs_if.ready);
		dates.note_seconds(item);
	endtask

	// Result side: random stalls, and each transfer is checked in order.
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
			stall = draw_gap(take_burst);
			if (stall > 0) begin
				date_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			date_if.ready <= 1'b1;
			do @(posedge clk); while (!date_if.valid);
			dates.check_date(date_if.data);
		end
	end

	function automatic logic [31:0] random_seconds();
		longint unsigned s, base;
		int unsigned y, m;
		int unsigned tod_edges[6] = '{0, 59, 60, 3599, 3600, 86399};
		case ($urandom_range(0, 9))
			0, 1, 2: s = $urandom;
			3, 4, 5: s = $urandom_range(0, 32'(days_to_month(YEAR_SPAN, 1) * SECS_DAY - 1));
			6, 7, 8: begin
				// Land just before or after a year or month boundary.
				y = $urandom_range(0, YEAR_SPAN);
				m = (y < YEAR_SPAN) ? $urandom_range(1, 12) : 1;
				if ($urandom_range(0, 1)) m = 1;
				base = days_to_month(y, m) * SECS_DAY;
				if ($urandom_range(0, 1) && base >= SECS_DAY)
					s = base - 1 - $urandom_range(0, SECS_DAY - 1);
				else
					s = base + $urandom_range(0, SECS_DAY - 1);
			end
			default: s = longint'($urandom_range(0, 49709)) * SECS_DAY
				+ tod_edges[$urandom_range(0, 5)];
		endcase
		return s[31:0];
	endfunction

	initial begin
		longint unsigned directed[$];
		longint unsigned span_end;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		span_end = days_to_month(YEAR_SPAN, 1) * SECS_DAY;
		directed = '{0, 59, 60, 3599, 3600, SECS_DAY - 1, SECS_DAY};
		directed.push_back(days_to_month(0, 2) * SECS_DAY);
		directed.push_back((days_to_month(0, 2) + 28) * SECS_DAY);    // leap day 2000
		directed.push_back(days_to_month(0, 3) * SECS_DAY);
		directed.push_back(days_to_month(1, 1) * SECS_DAY - 1);        // last second of 2000
		directed.push_back(days_to_month(1, 1) * SECS_DAY);
		directed.push_back(days_to_month(1, 3) * SECS_DAY - 1);        // Feb 28 in a common year
		directed.push_back(days_to_month(1, 3) * SECS_DAY);
		directed.push_back(days_to_month(50, 5) * SECS_DAY - 1);
		directed.push_back(days_to_month(96, 3) * SECS_DAY - 1);       // leap day 2096
		directed.push_back(span_end - 1);
		directed.push_back(span_end);
		directed.push_back(32'h7FFF_FFFF);
		directed.push_back(32'h8000_0000);
		directed.push_back(32'h5555_5555);
		directed.push_back(32'hAAAA_AAAA);
		directed.push_back(32'hFFFF_FFFF);
		foreach (directed[i]) send_seconds(directed[i][31:0]);

		repeat (RANDOM_ITEMS) send_seconds(random_seconds());
		secs_if.valid <= 1'b0;

		while (dates.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (dates.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/s2cd_pkg.sv
src/s2cd_stream_if.sv
src/s2cd_ctrl.sv
src/s2cd_dp.sv
src/seconds_to_calendar_date.sv
bench/seconds_to_calendar_date_tb.sv
